[rtl/oig_pkg.sv]
// ----------------------------------------------------------------------------
// oig_pkg
// shared types, message codes and constants of the order id generator
// ----------------------------------------------------------------------------
package oig_pkg;

  localparam int FUNC_W     = 4;
  localparam int CID_W      = 14;
  localparam int ID_W       = 32;
  localparam int CFG_W      = 4;
  localparam int SEQ_W      = 24;
  localparam int NEWS_W     = 20;
  localparam int TYPE_W     = 3;
  localparam int NUM_SLOTS  = 5;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CFG_W-1:0] CID_WIDTH_MIN   = 4'd5;
  localparam logic [CFG_W-1:0] CID_WIDTH_MAX   = 4'd14;
  localparam logic [CFG_W-1:0] CID_WIDTH_RESET = 4'd9;
  localparam logic [4:0]       SEQ_TOTAL_BITS  = 5'd29;

  localparam logic [NEWS_W-1:0] NEWS_WRAP  = 20'd999999;
  localparam logic [ID_W-1:0]   NEWS_SCALE = 32'd1000000;

  localparam logic [FUNC_W-1:0] FUNC_REPLACE_PRICE = 4'd0;
  localparam logic [FUNC_W-1:0] FUNC_NEW           = 4'd1;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL        = 4'd2;
  localparam logic [FUNC_W-1:0] FUNC_REPLACE       = 4'd3;
  localparam logic [FUNC_W-1:0] FUNC_QUOTE         = 4'd4;
  localparam logic [FUNC_W-1:0] FUNC_QUOTE_CANCEL  = 4'd5;
  localparam logic [FUNC_W-1:0] FUNC_QUOTE_REQ     = 4'd6;
  localparam logic [FUNC_W-1:0] FUNC_STATUS_REQ    = 4'd7;
  localparam logic [FUNC_W-1:0] FUNC_NEWS          = 4'd8;

  localparam logic [SLOT_W-1:0] SLOT_NEW          = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_CANCEL       = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_QUOTE        = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_QUOTE_CANCEL = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_REPLACE_GRP  = 3'd4;

  typedef enum logic [1:0] {
    KIND_PACKED,
    KIND_NEWS,
    KIND_INVALID
  } kind_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CID_W-1:0]  connection_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] network_id;
  } rsp_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [TYPE_W-1:0] type_code;
    logic [CID_W-1:0]  cid;
  } job_t;

endpackage

[rtl/oig_chan_if.sv]
// ----------------------------------------------------------------------------
// oig_chan_if
// valid/ready channel carrying one payload of a given type
// ----------------------------------------------------------------------------
interface oig_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/oig_front.sv]
// ----------------------------------------------------------------------------
// oig_front
// accepts requests and classifies the message type into a counter job
// ----------------------------------------------------------------------------
module oig_front (
  oig_chan_if.sink   req,
  oig_chan_if.source job
);
  import oig_pkg::*;

  job_t cls;

  always_comb begin
    cls.kind      = KIND_PACKED;
    cls.slot      = SLOT_REPLACE_GRP;
    cls.type_code = req.payload.func[TYPE_W-1:0];
    cls.cid       = req.payload.connection_id;
    unique case (req.payload.func) inside
      FUNC_NEW:          cls.slot = SLOT_NEW;
      FUNC_CANCEL:       cls.slot = SLOT_CANCEL;
      FUNC_QUOTE:        cls.slot = SLOT_QUOTE;
      FUNC_QUOTE_CANCEL: cls.slot = SLOT_QUOTE_CANCEL;
      FUNC_REPLACE_PRICE, FUNC_REPLACE, FUNC_QUOTE_REQ, FUNC_STATUS_REQ:
        cls.slot = SLOT_REPLACE_GRP;
      FUNC_NEWS:         cls.kind = KIND_NEWS;
      default:           cls.kind = KIND_INVALID;
    endcase
  end

  assign job.valid   = req.valid;
  assign job.payload = cls;
  assign req.ready   = job.ready;

endmodule

[rtl/oig_queue.sv]
// ----------------------------------------------------------------------------
// oig_queue
// short fifo between the classifier and the id generator
// ----------------------------------------------------------------------------
module oig_queue #(
  parameter int DEPTH = 2
) (
  input logic        clk,
  input logic        rst,
  oig_chan_if.sink   wr,
  oig_chan_if.source rd
);
  import oig_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr.ready   = (count != CNT_W'(DEPTH));
  assign rd.valid   = (count != '0);
  assign rd.payload = mem[rd_ptr];
  assign push       = wr.valid && wr.ready;
  assign pop        = rd.valid && rd.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_push_pop_count: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count missed a pop");

endmodule

[rtl/oig_back.sv]
// ----------------------------------------------------------------------------
// oig_back
// sequence counters, id packing and the result register
// ----------------------------------------------------------------------------
module oig_back (
  input logic                    clk,
  input logic                    rst,
  input logic [oig_pkg::CFG_W-1:0] cid_width,
  oig_chan_if.sink               job,
  oig_chan_if.source             rsp
);
  import oig_pkg::*;

  logic [SEQ_W-1:0]  counters [NUM_SLOTS];
  logic [NEWS_W-1:0] news_counter;
  logic              rsp_valid;
  logic [ID_W-1:0]   network_id;

  logic              take;
  logic [SEQ_W:0]    seq_limit;
  logic [CID_W-1:0]  cid_mask;
  logic [SEQ_W-1:0]  seq_cur;
  logic [SEQ_W-1:0]  seq;
  logic [ID_W-1:0]   packed_id;
  logic [NEWS_W-1:0] news_seq;
  logic [ID_W-1:0]   news_id;
  logic [ID_W-1:0]   network_id_next;
  logic [4:0]        seq_bits;
  logic [4:0]        seq_shift;

  assign take      = job.valid && job.ready;
  assign job.ready = !rsp_valid || rsp.ready;

  assign seq_bits  = SEQ_TOTAL_BITS - {1'b0, cid_width};
  assign seq_shift = {1'b0, cid_width} + 5'(TYPE_W);
  assign seq_limit = (SEQ_W + 1)'(1) << seq_bits;
  assign cid_mask  = CID_W'((CID_W + 1)'(1) << cid_width) - CID_W'(1);

  always_comb begin
    seq_cur   = counters[job.payload.slot];
    seq       = ({1'b0, seq_cur} >= seq_limit) ? '0 : seq_cur;
    packed_id = (ID_W'(seq) << seq_shift)
              | (ID_W'(job.payload.cid & cid_mask) << TYPE_W)
              | ID_W'(job.payload.type_code);
    news_seq  = (news_counter >= NEWS_WRAP) ? '0 : news_counter;
    news_id   = ID_W'(news_seq) + ID_W'(ID_W'(job.payload.cid) * NEWS_SCALE);
    case (job.payload.kind)
      KIND_PACKED: network_id_next = packed_id;
      KIND_NEWS:   network_id_next = news_id;
      default:     network_id_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        counters[i] <= '0;
      end
      news_counter <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (take) begin
        rsp_valid <= 1'b1;
        if (job.payload.kind == KIND_PACKED) begin
          counters[job.payload.slot] <= seq + 1'b1;
        end
        if (job.payload.kind == KIND_NEWS) begin
          news_counter <= news_seq + 1'b1;
        end
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      network_id <= network_id_next;
    end
  end

  assign rsp.valid              = rsp_valid;
  assign rsp.payload.network_id = network_id;

  a_take_shows: assert property (@(posedge clk) disable iff (rst)
    take |=> rsp_valid)
    else $error("accepted job left no result");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (take && job.payload.kind == KIND_INVALID) |=> (network_id == '0))
    else $error("invalid type gave a nonzero id");

  a_news_bound: assert property (@(posedge clk) disable iff (rst)
    news_counter <= NEWS_WRAP)
    else $error("news counter past its wrap point");

endmodule

[rtl/order_id_generator.sv]
// ----------------------------------------------------------------------------
// order_id_generator
// per-request 32-bit network id generator
//
// req carries func and connection_id, rsp returns one network_id for every
// request in order. cfg writes cid_width (saturated to 5..14) and is always
// ready; write it only while no request is in flight.
// A request is classified at the input, passes a short fifo, and the id is
// formed in the cycle it leaves the fifo, from the counter selected by its
// type, into a result register. An accepted request is written to the fifo
// and then to the result register, which drives rsp.valid. One request per
// cycle is taken while rsp does not stall. When rsp stalls the result
// register holds, the fifo fills and then req ready drops; nothing is lost.
// Synchronous reset clears all counters to zero, sets cid_width to 9 and
// empties the fifo; no clearing pass.
// ----------------------------------------------------------------------------
module order_id_generator #(
  parameter int QUEUE_DEPTH = oig_pkg::QUEUE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  oig_chan_if.sink   req,
  oig_chan_if.sink   cfg,
  oig_chan_if.source rsp
);
  import oig_pkg::*;

  logic [CFG_W-1:0] cid_width;

  oig_chan_if #(.payload_t(job_t)) front_q ();
  oig_chan_if #(.payload_t(job_t)) q_back ();

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cid_width <= CID_WIDTH_RESET;
    end else if (cfg.valid) begin
      if (CFG_W'(cfg.payload) < CID_WIDTH_MIN) begin
        cid_width <= CID_WIDTH_MIN;
      end else if (CFG_W'(cfg.payload) > CID_WIDTH_MAX) begin
        cid_width <= CID_WIDTH_MAX;
      end else begin
        cid_width <= CFG_W'(cfg.payload);
      end
    end
  end

  oig_front u_front (
    .req (req),
    .job (front_q)
  );

  oig_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (front_q),
    .rd  (q_back)
  );

  oig_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cid_width (cid_width),
    .job       (q_back),
    .rsp       (rsp)
  );

endmodule
